// ===== sv/jsd_pkg.sv =====
// Shared types, byte codes and mapping functions of the JSON string value decoder.
`default_nettype none

package jsd_pkg;

   // Result slots that one input byte can fill
   localparam int MAX_RESULTS = 5;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int SIZE_W      = 9;

   localparam logic [SIZE_W-1:0] OUT_SIZE_RESET = SIZE_W'(32);

   // Outcome codes
   localparam logic [1:0] STATUS_CLOSED   = 2'd0;
   localparam logic [1:0] STATUS_UNCLOSED = 2'd1;
   localparam logic [1:0] STATUS_FAIL     = 2'd2;

   // Byte codes of the syntax
   localparam logic [7:0] BYTE_NUL    = 8'h00;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_BSLASH   = 8'h5c;
   localparam logic [7:0] CH_ESC_U    = 8'h75;
   localparam logic [7:0] CH_ESC_N    = 8'h6e;
   localparam logic [7:0] CH_ESC_R    = 8'h72;
   localparam logic [7:0] CH_ESC_T    = 8'h74;
   localparam logic [7:0] BYTE_LEAD   = 8'hc3;
   localparam logic [7:0] ASCII_LIMIT = 8'h80;

   // Latin-1 letters that are spelt out as two letters
   localparam logic [7:0] LAT_A_UML  = 8'he4;
   localparam logic [7:0] LAT_O_UML  = 8'hf6;
   localparam logic [7:0] LAT_U_UML  = 8'hfc;
   localparam logic [7:0] LAT_CA_UML = 8'hc4;
   localparam logic [7:0] LAT_CO_UML = 8'hd6;
   localparam logic [7:0] LAT_CU_UML = 8'hdc;
   localparam logic [7:0] LAT_SZ     = 8'hdf;

   typedef enum logic [2:0] {
      MODE_SEEK,
      MODE_STR,
      MODE_ESC,
      MODE_HEX,
      MODE_LEAD,
      MODE_DRAIN
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic [1:0]            hex_count;
      logic [2:0][7:0]       hex_chars;
      logic [11:0]           hex_code;
      logic [SIZE_W-1:0]     stored_count;
   } state_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       done_res;
      logic [1:0] status;
   } result_type;

   // Results of one input byte, in delivery order from entry 0
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] entry;
      logic [COUNT_W-1:0]           count;
   } batch_type;

   typedef struct packed {
      logic [1:0] n;
      logic [7:0] c0;
      logic [7:0] c1;
   } lat_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   // Map a Latin-1 byte to zero, one or two printable characters
   function automatic lat_type latin1_map(input logic [7:0] c);
      lat_type r;
      r = '0;
      case (c)
         LAT_A_UML:  begin r.n = 2'd2; r.c0 = "a"; r.c1 = "e"; end
         LAT_O_UML:  begin r.n = 2'd2; r.c0 = "o"; r.c1 = "e"; end
         LAT_U_UML:  begin r.n = 2'd2; r.c0 = "u"; r.c1 = "e"; end
         LAT_CA_UML: begin r.n = 2'd2; r.c0 = "A"; r.c1 = "e"; end
         LAT_CO_UML: begin r.n = 2'd2; r.c0 = "O"; r.c1 = "e"; end
         LAT_CU_UML: begin r.n = 2'd2; r.c0 = "U"; r.c1 = "e"; end
         LAT_SZ:     begin r.n = 2'd2; r.c0 = "s"; r.c1 = "s"; end
         default: begin
            if (c inside {[8'd32:8'd126]}) begin
               r.n  = 2'd1;
               r.c0 = c;
            end
         end
      endcase
      return r;
   endfunction

   // Decode one hex digit
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r = '0;
      if (c inside {[8'h30:8'h39]}) begin
         r.ok  = 1'b1;
         r.val = 4'(c - 8'h30);
      end else if (c inside {[8'h61:8'h66]}) begin
         r.ok  = 1'b1;
         r.val = 4'(c - 8'h57);
      end else if (c inside {[8'h41:8'h46]}) begin
         r.ok  = 1'b1;
         r.val = 4'(c - 8'h37);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/jsd_decode.sv =====
// Combinational decode of one byte: next state and the ordered batch of results.
`default_nettype none

module jsd_decode
   import jsd_pkg::*;
(
   input  wire state_type         st,
   input  wire logic [7:0]        in_byte,
   input  wire logic [SIZE_W-1:0] out_size,
   output state_type              st_next,
   output batch_type              batch
);

   always_comb begin
      logic [7:0]        pre [4];
      logic [2:0]        npre;
      logic [7:0]        suf0;
      logic [7:0]        suf1;
      logic [1:0]        nsuf;
      logic              done;
      logic [1:0]        dst;
      mode_type          sb_mode;
      logic [1:0]        sb_n;
      logic [7:0]        sb_c0;
      logic [7:0]        sb_c1;
      logic              sb_done;
      logic [1:0]        sb_status;
      lat_type           lat;
      hex_type           hx;
      logic [7:0]        cand [MAX_RESULTS];
      logic [2:0]        ncand;
      logic [2:0]        rel;
      logic [SIZE_W-1:0] cap;
      logic [SIZE_W-1:0] room;
      logic [2:0]        nkeep;

      // Ordinary string content, used by the string mode and after a bad hex escape
      sb_mode   = MODE_STR;
      sb_n      = 2'd0;
      sb_c0     = '0;
      sb_c1     = '0;
      sb_done   = 1'b0;
      sb_status = STATUS_CLOSED;
      lat       = latin1_map(in_byte);
      if (in_byte == BYTE_NUL) begin
         sb_done   = 1'b1;
         sb_status = STATUS_UNCLOSED;
         sb_mode   = MODE_SEEK;
      end else if (in_byte == CH_QUOTE) begin
         sb_done   = 1'b1;
         sb_status = STATUS_CLOSED;
         sb_mode   = MODE_DRAIN;
      end else if (in_byte == CH_BSLASH) begin
         sb_mode = MODE_ESC;
      end else if (in_byte == BYTE_LEAD) begin
         sb_mode = MODE_LEAD;
      end else if (in_byte < ASCII_LIMIT) begin
         sb_n  = 2'd1;
         sb_c0 = in_byte;
      end else begin
         sb_n  = lat.n;
         sb_c0 = lat.c0;
         sb_c1 = lat.c1;
      end

      // Per mode: replayed prefix, trailing characters, outcome and next state
      st_next = st;
      for (int i = 0; i < 4; i++) pre[i] = '0;
      npre = '0;
      suf0 = '0;
      suf1 = '0;
      nsuf = '0;
      done = 1'b0;
      dst  = STATUS_CLOSED;
      hx   = hex_decode(in_byte);
      case (st.mode)
         MODE_STR: begin
            suf0         = sb_c0;
            suf1         = sb_c1;
            nsuf         = sb_n;
            done         = sb_done;
            dst          = sb_status;
            st_next.mode = sb_mode;
         end
         MODE_ESC: begin
            if (in_byte == BYTE_NUL) begin
               suf0         = CH_BSLASH;
               nsuf         = 2'd1;
               done         = 1'b1;
               dst          = STATUS_UNCLOSED;
               st_next.mode = MODE_SEEK;
            end else if (in_byte == CH_ESC_U) begin
               st_next.hex_count = '0;
               st_next.hex_code  = '0;
               st_next.mode      = MODE_HEX;
            end else begin
               st_next.mode = MODE_STR;
               if (in_byte != CH_ESC_N && in_byte != CH_ESC_R && in_byte != CH_ESC_T) begin
                  suf0 = in_byte;
                  nsuf = 2'd1;
               end
            end
         end
         MODE_HEX: begin
            if (in_byte == BYTE_NUL) begin
               // Replay 'u' and the digits taken so far, then report unclosed
               pre[0] = CH_ESC_U;
               pre[1] = st.hex_chars[0];
               pre[2] = st.hex_chars[1];
               pre[3] = st.hex_chars[2];
               npre   = 3'd1 + {1'b0, st.hex_count};
               done   = 1'b1;
               dst    = STATUS_UNCLOSED;
               st_next.mode      = MODE_SEEK;
               st_next.hex_count = '0;
               st_next.hex_code  = '0;
            end else if (!hx.ok) begin
               // Drop the escape, replay digits and treat the byte as content
               pre[0] = st.hex_chars[0];
               pre[1] = st.hex_chars[1];
               pre[2] = st.hex_chars[2];
               npre   = {1'b0, st.hex_count};
               suf0   = sb_c0;
               suf1   = sb_c1;
               nsuf   = sb_n;
               done   = sb_done;
               dst    = sb_status;
               st_next.mode      = sb_mode;
               st_next.hex_count = '0;
               st_next.hex_code  = '0;
            end else if (st.hex_count == 2'd3) begin
               st_next.mode      = MODE_STR;
               st_next.hex_count = '0;
               st_next.hex_code  = '0;
               if (st.hex_code[11:4] == '0) begin
                  lat  = latin1_map({st.hex_code[3:0], hx.val});
                  suf0 = lat.c0;
                  suf1 = lat.c1;
                  nsuf = lat.n;
               end
            end else begin
               st_next.hex_chars[st.hex_count] = in_byte;
               st_next.hex_count = st.hex_count + 2'd1;
               st_next.hex_code  = {st.hex_code[7:0], hx.val};
            end
         end
         MODE_LEAD: begin
            if (in_byte == BYTE_NUL) begin
               done         = 1'b1;
               dst          = STATUS_UNCLOSED;
               st_next.mode = MODE_SEEK;
            end else begin
               suf0         = lat.c0;
               suf1         = lat.c1;
               nsuf         = lat.n;
               st_next.mode = MODE_STR;
            end
         end
         MODE_DRAIN: begin
            if (in_byte == BYTE_NUL) st_next.mode = MODE_SEEK;
         end
         default: begin
            // Seek the opening quote
            if (in_byte == BYTE_NUL) begin
               done         = 1'b1;
               dst          = STATUS_FAIL;
               st_next.mode = MODE_SEEK;
            end else if (out_size == '0) begin
               done         = 1'b1;
               dst          = STATUS_FAIL;
               st_next.mode = MODE_DRAIN;
            end else if (in_byte == CH_QUOTE) begin
               st_next.stored_count = '0;
               st_next.hex_count    = '0;
               st_next.hex_code     = '0;
               st_next.mode         = MODE_STR;
            end
         end
      endcase

      // Line up candidate characters: replayed prefix, then trailing characters
      ncand = npre + {1'b0, nsuf};
      for (int i = 0; i < MAX_RESULTS; i++) begin
         rel = 3'(i) - npre;
         if (3'(i) < npre) cand[i] = pre[i % 4];
         else if (rel == 3'd0) cand[i] = suf0;
         else cand[i] = suf1;
      end

      // Keep the prefix that still fits the destination
      cap   = (out_size == '0) ? '0 : out_size - SIZE_W'(1);
      room  = (st.stored_count < cap) ? cap - st.stored_count : '0;
      nkeep = (room < {{(SIZE_W-3){1'b0}}, ncand}) ? room[2:0] : ncand;
      st_next.stored_count = st_next.stored_count + {{(SIZE_W-3){1'b0}}, nkeep};

      // Kept characters first, the outcome after them
      for (int i = 0; i < MAX_RESULTS; i++) begin
         batch.entry[i] = '0;
         if (3'(i) < nkeep) begin
            batch.entry[i].out_char   = cand[i];
            batch.entry[i].char_valid = 1'b1;
         end else if (3'(i) == nkeep && done) begin
            batch.entry[i].done_res = 1'b1;
            batch.entry[i].status   = dst;
         end
      end
      batch.count = COUNT_W'(nkeep) + COUNT_W'(done);
   end

endmodule

`default_nettype wire

// ===== sv/jsd_result_queue.sv =====
// Result register: holds the batch of one byte and hands it out one result per cycle while the receiver is ready.
`default_nettype none

module jsd_result_queue
   import jsd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire batch_type  batch,
   output logic            free,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_char_valid,
   output logic            rsp_done_res,
   output logic [1:0]      rsp_status,
   output logic            rsp_last
);

   result_type         list_ff [MAX_RESULTS];
   logic [COUNT_W-1:0] count_ff;
   logic               pop;

   assign pop  = rsp_valid && rsp_ready;
   // Room for a new batch when empty, or once the final result leaves this cycle
   assign free = (count_ff == '0) || ((count_ff == COUNT_W'(1)) && rsp_ready);

   // Track the number of results still held
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= batch.count;
      end else if (pop) begin
         count_ff <= count_ff - COUNT_W'(1);
      end
   end

   // Load a batch, or advance the remaining results towards the head
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MAX_RESULTS; i++) list_ff[i] <= batch.entry[i];
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) list_ff[i] <= list_ff[i+1];
      end
   end

   assign rsp_valid      = (count_ff != '0);
   assign rsp_out_char   = list_ff[0].out_char;
   assign rsp_char_valid = list_ff[0].char_valid;
   assign rsp_done_res   = list_ff[0].done_res;
   assign rsp_status     = list_ff[0].status;
   assign rsp_last       = (count_ff == COUNT_W'(1));

endmodule

`default_nettype wire

// ===== sv/json_string_value_decoder_top.sv =====
// Top level of the JSON string value decoder: input register, decode state and result register.
//
// Usage: text bytes that follow a key's colon arrive on the req_ channel, one byte per
// request; a zero byte ends the text. Decoded characters and the string outcome leave on
// the rsp_ channel, one result per handshake, with rsp_last on the final result of a byte.
// A byte may give no result at all (skipped or dropped bytes) or up to five results.
// The destination size is written through the csr_ channel, which is always ready, and
// must only be changed while the block is idle; it resets to 32.
// An accepted byte waits in the input register, is decoded combinationally and has its
// results loaded into the result register, whose head drives the rsp_ ports.
// Throughput: one byte per cycle while each byte gives at most one result and the receiver
// is ready; a byte with several results occupies the result register until all are taken,
// while the input register holds the next byte; the one-result-per-cycle output sets the rate.
// Reset (synchronous, active high) empties both registers and returns the decoder to the
// search for an opening quote with an empty destination.
// When the receiver stalls, the current result is held unchanged; bytes that give no
// result still pass, and once a byte with results waits in the input register req_ready
// drops until room frees up.
`default_nettype none

module json_string_value_decoder_top
   import jsd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [SIZE_W-1:0] csr_out_size,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_in_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_char_valid,
   output logic                   rsp_done_res,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last
);

   logic [SIZE_W-1:0] out_size_ff;
   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   state_type         state_ff;
   state_type         state_in;
   batch_type         batch;
   logic              free;
   logic              advance;

   // Destination size register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_size_ff <= OUT_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         out_size_ff <= csr_out_size;
      end
   end

   // Move the held byte on when its results fit, or when it gives none
   assign advance   = in_valid_ff && (free || (batch.count == '0));
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_in_byte;
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode         <= MODE_SEEK;
         state_ff.hex_count    <= '0;
         state_ff.hex_chars    <= '0;
         state_ff.hex_code     <= '0;
         state_ff.stored_count <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   jsd_decode u_decode (
      .st       (state_ff),
      .in_byte  (in_byte_ff),
      .out_size (out_size_ff),
      .st_next  (state_in),
      .batch    (batch)
   );

   jsd_result_queue u_queue (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && (batch.count != '0)),
      .batch          (batch),
      .free           (free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_done_res   (rsp_done_res),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sv/jsd_checker.sv =====
// Port-level checks of the JSON string value decoder and their binding to the top level.
`default_nettype none

module jsd_checker
   import jsd_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [7:0]        rsp_out_char,
   input wire logic              rsp_char_valid,
   input wire logic              rsp_done_res,
   input wire logic [1:0]        rsp_status,
   input wire logic              rsp_last
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_char_valid) && $stable(rsp_done_res) && $stable(rsp_status)
         && $stable(rsp_last))
      else $error("result changed while stalled");

   // The outcome is always the final result of its byte
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_last)
      else $error("outcome not marked last");

   // A character result carries no outcome
   a_char_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_valid |-> !rsp_done_res && rsp_status == STATUS_CLOSED)
      else $error("character result carries an outcome");

   // Reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind json_string_value_decoder_top jsd_checker u_jsd_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the JSON string value decoder: byte stimulus, prediction, result checks.
`timescale 1ns / 100ps

module tb;
   import jsd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 26;
   localparam int DRAIN_WAIT  = 6;

   typedef struct packed {
      logic [7:0] ch;
      logic       valid;
      logic       done;
      logic [1:0] status;
      logic       last;
   } char_result_type;

   // Decoder predictor plus the queue of characters and outcomes still owed by the block
   class unescape_checker;
      char_result_type expected_chars[$];
      char_result_type step_results[$];
      mode_type        mode = MODE_SEEK;
      int unsigned     hex_n = 0;
      logic [7:0]      hex_digits [3] = '{default: 8'h00};
      logic [15:0]     hex_acc = '0;
      logic [SIZE_W-1:0] stored = '0;
      logic [SIZE_W-1:0] size = OUT_SIZE_RESET;
      int              errors = 0;

      function void push_result(logic [7:0] ch, logic valid, logic done, logic [1:0] st);
         char_result_type r;
         r = '{ch, valid, done, st, 1'b0};
         if (step_results.size() < MAX_RESULTS)
            step_results.push_back(r);
      endfunction

      // Store one character while the destination has room; status reads zero on characters
      function void put_char(logic [7:0] c);
         logic [SIZE_W-1:0] cap;
         cap = (size == 0) ? '0 : size - 1'b1;
         if (stored < cap) begin
            stored++;
            push_result(c, 1'b1, 1'b0, STATUS_CLOSED);
         end
      endfunction

      // Spell out umlauts and sharp s, pass printable ASCII, drop the rest
      function void put_latin(logic [7:0] c);
         case (c)
            LAT_A_UML:  begin put_char("a"); put_char("e"); end
            LAT_O_UML:  begin put_char("o"); put_char("e"); end
            LAT_U_UML:  begin put_char("u"); put_char("e"); end
            LAT_CA_UML: begin put_char("A"); put_char("e"); end
            LAT_CO_UML: begin put_char("O"); put_char("e"); end
            LAT_CU_UML: begin put_char("U"); put_char("e"); end
            LAT_SZ:     begin put_char("s"); put_char("s"); end
            default: begin
               if (c >= 8'd32 && c < 8'd127)
                  put_char(c);
            end
         endcase
      endfunction

      function int nibble_of(logic [7:0] c);
         if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
         if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
         if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
         return -1;
      endfunction

      // Give back the digits of an unfinished escape as plain characters
      function void replay_hex();
         for (int i = 0; i < hex_n && i < 3; i++)
            put_char(hex_digits[i]);
         hex_n   = 0;
         hex_acc = '0;
      endfunction

      function void string_byte(logic [7:0] b);
         if (b == BYTE_NUL) begin
            push_result(8'h00, 1'b0, 1'b1, STATUS_UNCLOSED);
            mode = MODE_SEEK;
         end else if (b == CH_QUOTE) begin
            push_result(8'h00, 1'b0, 1'b1, STATUS_CLOSED);
            mode = MODE_DRAIN;
         end else if (b == CH_BSLASH) begin
            mode = MODE_ESC;
         end else if (b == BYTE_LEAD) begin
            mode = MODE_LEAD;
         end else if (b < ASCII_LIMIT) begin
            put_char(b);
         end else begin
            put_latin(b);
         end
      endfunction

      // Advance the predictor by one accepted request and queue what it should produce
      function void decode_byte(logic [7:0] b);
         int          d;
         logic [15:0] code;
         step_results.delete();
         case (mode)
            MODE_STR: string_byte(b);
            MODE_ESC: begin
               if (b == BYTE_NUL) begin
                  put_char(CH_BSLASH);
                  push_result(8'h00, 1'b0, 1'b1, STATUS_UNCLOSED);
                  mode = MODE_SEEK;
               end else if (b == CH_ESC_U) begin
                  hex_n   = 0;
                  hex_acc = '0;
                  mode    = MODE_HEX;
               end else begin
                  mode = MODE_STR;
                  if (b != CH_ESC_N && b != CH_ESC_R && b != CH_ESC_T)
                     put_char(b);
               end
            end
            MODE_HEX: begin
               d = nibble_of(b);
               if (b == BYTE_NUL) begin
                  put_char(CH_ESC_U);
                  replay_hex();
                  push_result(8'h00, 1'b0, 1'b1, STATUS_UNCLOSED);
                  mode = MODE_SEEK;
               end else if (d < 0) begin
                  replay_hex();
                  mode = MODE_STR;
                  string_byte(b);
               end else if (hex_n >= 3) begin
                  code    = {hex_acc[11:0], 4'(d)};
                  hex_n   = 0;
                  hex_acc = '0;
                  mode    = MODE_STR;
                  if (code <= 16'd255)
                     put_latin(code[7:0]);
               end else begin
                  hex_digits[hex_n] = b;
                  hex_n++;
                  hex_acc = {hex_acc[11:0], 4'(d)};
               end
            end
            MODE_LEAD: begin
               if (b == BYTE_NUL) begin
                  push_result(8'h00, 1'b0, 1'b1, STATUS_UNCLOSED);
                  mode = MODE_SEEK;
               end else begin
                  put_latin(b);
                  mode = MODE_STR;
               end
            end
            MODE_DRAIN: begin
               if (b == BYTE_NUL)
                  mode = MODE_SEEK;
            end
            default: begin
               if (b == BYTE_NUL) begin
                  push_result(8'h00, 1'b0, 1'b1, STATUS_FAIL);
                  mode = MODE_SEEK;
               end else if (size == 0) begin
                  push_result(8'h00, 1'b0, 1'b1, STATUS_FAIL);
                  mode = MODE_DRAIN;
               end else if (b == CH_QUOTE) begin
                  stored  = '0;
                  hex_n   = 0;
                  hex_acc = '0;
                  mode    = MODE_STR;
               end
            end
         endcase
         if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
         foreach (step_results[i])
            expected_chars.push_back(step_results[i]);
      endfunction

      function void compare_field(string label, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         end
      endfunction

      // Match one delivered result against the oldest outstanding one
      function void check_result(logic [7:0] ch, logic valid, logic done, logic [1:0] st,
                                 logic last);
         char_result_type want;
         if (expected_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual char %0h valid %0b done %0b",
                     $time, ch, valid, done);
            return;
         end
         want = expected_chars.pop_front();
         compare_field("out_char", want.ch, ch);
         compare_field("char_valid", want.valid, valid);
         compare_field("done_res", want.done, done);
         compare_field("status", want.status, st);
         compare_field("last", want.last, last);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_out_size;
   logic              req_valid;
   logic              req_ready;
   logic [7:0]        req_in_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [7:0]        rsp_out_char;
   logic              rsp_char_valid;
   logic              rsp_done_res;
   logic [1:0]        rsp_status;
   logic              rsp_last;

   unescape_checker board = new;
   int              items_sent = 0;
   bit              no_idle = 1'b0;
   bit              hold_off_req = 1'b0;

   // Opening text: skip, escapes, \u to umlaut, lead byte, dropped byte, wide code, bad hex,
   // then no opening quote, backslash at end, lead byte at end and a short \u at end
   logic [7:0] opening_text [$] = '{
      8'h20, CH_QUOTE, CH_BSLASH, CH_ESC_N, CH_BSLASH, "q", CH_BSLASH, CH_ESC_U,
      "0", "0", "e", "4", BYTE_LEAD, LAT_SZ, 8'hff, CH_BSLASH, CH_ESC_U, "1", "2", "3",
      "4", CH_BSLASH, CH_ESC_U, "4", "G", CH_QUOTE, "x", BYTE_NUL,
      BYTE_NUL,
      CH_QUOTE, CH_BSLASH, BYTE_NUL,
      CH_QUOTE, BYTE_LEAD, BYTE_NUL,
      CH_QUOTE, CH_BSLASH, CH_ESC_U, "4", "1", BYTE_NUL
   };
   // Tiny destination: the umlaut is cut after its first letter
   logic [7:0] cut_text [$] = '{CH_QUOTE, "a", LAT_A_UML, CH_QUOTE, BYTE_NUL};
   // Zero-size destination: fail at once, then drain to the zero byte
   logic [7:0] zero_size_text [$] = '{"x", "y", BYTE_NUL};

   json_string_value_decoder_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_out_size   (csr_out_size),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_done_res   (rsp_done_res),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Offer one byte, with random idle cycles ahead of it; return at the falling edge
   task automatic send_byte(input logic [7:0] b);
      while (!no_idle && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      board.decode_byte(b);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold the sender until every outstanding result has been delivered
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (board.expected_chars.size() != 0)
         @(negedge clock);
   endtask

   // Write the destination size once the block has gone quiet
   task automatic write_size(input logic [SIZE_W-1:0] v);
      pause_until_drained();
      repeat (DRAIN_WAIT) @(negedge clock);
      csr_valid    <= 1'b1;
      csr_out_size <= v;
      do @(posedge clock); while (!csr_ready);
      board.size = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] hex_char(input int v);
      if (v < 10)
         return 8'(int'("0") + v);
      return 8'(($urandom_range(1) ? int'("A") : int'("a")) + v - 10);
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      do b = 8'($urandom_range(32, 126)); while (b == CH_QUOTE || b == CH_BSLASH);
      return b;
   endfunction

   function automatic logic [7:0] umlaut_byte();
      case ($urandom_range(6))
         0: return LAT_A_UML;
         1: return LAT_O_UML;
         2: return LAT_U_UML;
         3: return LAT_CA_UML;
         4: return LAT_CO_UML;
         5: return LAT_CU_UML;
         default: return LAT_SZ;
      endcase
   endfunction

   // One piece of string content: plain, escape, \u, broken \u, lead pair, umlaut or noise
   task automatic send_token();
      int         r;
      logic [7:0] b;
      r = $urandom_range(99);
      if (r < 45) begin
         send_byte(plain_char());
      end else if (r < 55) begin
         send_byte(CH_BSLASH);
         case ($urandom_range(5))
            0: send_byte(CH_ESC_N);
            1: send_byte(CH_ESC_R);
            2: send_byte(CH_ESC_T);
            3: send_byte(CH_QUOTE);
            4: send_byte(CH_BSLASH);
            default: send_byte(plain_char());
         endcase
      end else if (r < 67) begin
         send_byte(CH_BSLASH);
         send_byte(CH_ESC_U);
         if ($urandom_range(3) != 0) begin
            send_byte("0");
            send_byte("0");
         end else begin
            send_byte(hex_char($urandom_range(15)));
            send_byte(hex_char($urandom_range(15)));
         end
         send_byte(hex_char($urandom_range(15)));
         send_byte(hex_char($urandom_range(15)));
      end else if (r < 73) begin
         send_byte(CH_BSLASH);
         send_byte(CH_ESC_U);
         repeat ($urandom_range(3)) send_byte(hex_char($urandom_range(15)));
         do b = plain_char(); while (board.nibble_of(b) >= 0);
         send_byte(b);
      end else if (r < 82) begin
         send_byte(BYTE_LEAD);
         send_byte($urandom_range(1) ? umlaut_byte() : 8'($urandom_range(1, 255)));
      end else if (r < 92) begin
         send_byte(umlaut_byte());
      end else begin
         send_byte(8'($urandom_range(1, 255)));
      end
   endtask

   // One text up to its zero byte: mostly a quoted string, sometimes plain noise
   task automatic send_text();
      int         r;
      int         n;
      logic [7:0] b;
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
         send_byte(BYTE_NUL);
         return;
      end
      repeat ($urandom_range(2)) begin
         do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
         send_byte(b);
      end
      send_byte(CH_QUOTE);
      n = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
      repeat (n) send_token();
      r = $urandom_range(99);
      if (r < 70) begin
         send_byte(CH_QUOTE);
         repeat ($urandom_range(3)) send_byte(8'($urandom_range(1, 255)));
      end else if (r < 80) begin
         // end of text inside the string
      end else if (r < 88) begin
         send_byte(CH_BSLASH);
      end else if (r < 94) begin
         send_byte(CH_BSLASH);
         send_byte(CH_ESC_U);
         repeat ($urandom_range(3)) send_byte(hex_char($urandom_range(15)));
      end else begin
         send_byte(BYTE_LEAD);
      end
      send_byte(BYTE_NUL);
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (90) @(negedge clock);
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 29);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_out_char, rsp_char_valid, rsp_done_res, rsp_status, rsp_last);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [SIZE_W-1:0] sizes [8];
      int                phase_start;
      bit                paused;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_in_byte  = 8'h00;
      csr_valid    = 1'b0;
      csr_out_size = '0;
      paused       = 1'b0;
      sizes = '{9'd256, 9'd1, 9'd4, 9'd0, 9'd255, 9'd0, 9'd3, 9'd32};
      sizes[5] = SIZE_W'($urandom_range(0, 256));
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed texts at the reset size, then a tiny and a zero-size destination
      foreach (opening_text[i]) send_byte(opening_text[i]);
      write_size(9'd3);
      foreach (cut_text[i]) send_byte(cut_text[i]);
      write_size(9'd0);
      foreach (zero_size_text[i]) send_byte(zero_size_text[i]);

      // Random phases, one destination size each
      for (int p = 0; p < 8; p++) begin
         write_size(sizes[p]);
         no_idle = (p == 5);
         if (p == 0)
            hold_off_req = 1'b1;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            send_text();
            if (p == 2 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
               pause_until_drained();
               paused = 1'b1;
            end
         end
      end
      no_idle = 1'b0;

      // Let the tail drain, then allow time for any stray result
      pause_until_drained();
      repeat (20) @(negedge clock);
      if (board.errors == 0 && board.expected_chars.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/jsd_pkg.sv
sv/jsd_decode.sv
sv/jsd_result_queue.sv
sv/json_string_value_decoder_top.sv
sv/jsd_checker.sv
tb/tb.sv
